FILE: rtl/i2p_pkg.sv
package i2p_pkg;

   // Operator stack geometry.
   localparam int STACK_DEPTH = 16;
   localparam int IDX_W       = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

   // Character codes the converter recognizes.
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_NONE   = 8'h00;

   // Status codes carried on every result.
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_UNMATCHED = 2'd1;
   localparam logic [1:0] ST_OVERFLOW  = 2'd2;

   // Microprogram step addresses.
   localparam int UPC_W = 5;
   localparam logic [UPC_W-1:0] S_IDLE  = 5'd0;
   localparam logic [UPC_W-1:0] S_DISP0 = 5'd1;
   localparam logic [UPC_W-1:0] S_DISP1 = 5'd2;
   localparam logic [UPC_W-1:0] S_DISP2 = 5'd3;
   localparam logic [UPC_W-1:0] S_OPER  = 5'd4;
   localparam logic [UPC_W-1:0] S_OPCMP = 5'd5;
   localparam logic [UPC_W-1:0] S_OPPOP = 5'd6;
   localparam logic [UPC_W-1:0] S_PUSH  = 5'd7;
   localparam logic [UPC_W-1:0] S_OPND  = 5'd8;
   localparam logic [UPC_W-1:0] S_OPEN  = 5'd9;
   localparam logic [UPC_W-1:0] S_CLOSE = 5'd10;
   localparam logic [UPC_W-1:0] S_CLTOP = 5'd11;
   localparam logic [UPC_W-1:0] S_CLPOP = 5'd12;
   localparam logic [UPC_W-1:0] S_UNM   = 5'd13;
   localparam logic [UPC_W-1:0] S_DROP  = 5'd14;
   localparam logic [UPC_W-1:0] S_LAST  = 5'd15;
   localparam logic [UPC_W-1:0] S_FLUSH = 5'd16;
   localparam logic [UPC_W-1:0] S_FLPOP = 5'd17;
   localparam logic [UPC_W-1:0] S_FIN   = 5'd18;

   // Branch conditions a control word can test.
   typedef enum logic [3:0] {
      C_NEVER,
      C_ALWAYS,
      C_NO_REQ,
      C_OPERAND,
      C_OPEN,
      C_CLOSE,
      C_EMPTY,
      C_TOP_OPEN,
      C_PREC_POPS,
      C_LAST
   } cond_type;

   // Source of a produced result.
   typedef enum logic [1:0] {
      PUT_NONE,
      PUT_CHAR,
      PUT_TOP
   } put_type;

   // One microcode control word.
   typedef struct packed {
      logic             take;
      put_type          put;
      logic             pop;
      logic             push;
      logic             flag_close;
      logic             fin;
      cond_type         cond;
      logic             inv;
      logic [UPC_W-1:0] target;
   } ctl_word_type;

   // Datapath flags returned to the sequencer.
   typedef struct packed {
      logic no_req;
      logic operand;
      logic open;
      logic close;
      logic empty;
      logic top_open;
      logic prec_pops;
      logic last;
      logic hold;
   } dp_flags_type;

   // Precedence, biased by one so that "other" characters rank 0.
   function automatic logic [2:0] prec_of(input logic [7:0] c);
      logic [2:0] p;
      case (c)
         CH_PLUS, CH_MINUS: p = 3'd2;
         CH_STAR, CH_SLASH: p = 3'd3;
         CH_CARET:          p = 3'd4;
         CH_LPAREN:         p = 3'd1;
         default:           p = 3'd0;
      endcase
      return p;
   endfunction

   function automatic logic is_operand(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h30 && c <= 8'h39);
   endfunction

   function automatic ctl_word_type cw(input logic take, input put_type put,
                                       input logic pop, input logic push,
                                       input logic flag_close, input logic fin,
                                       input cond_type cond, input logic inv,
                                       input logic [UPC_W-1:0] target);
      ctl_word_type w;
      w.take       = take;
      w.put        = put;
      w.pop        = pop;
      w.push       = push;
      w.flag_close = flag_close;
      w.fin        = fin;
      w.cond       = cond;
      w.inv        = inv;
      w.target     = target;
      return w;
   endfunction

   // The microprogram. A taken branch goes to target, otherwise to the next step.
   function automatic ctl_word_type microcode(input logic [UPC_W-1:0] upc);
      ctl_word_type w;
      case (upc)
         S_IDLE:  w = cw(1'b1, PUT_NONE, 1'b0, 1'b0, 1'b0, 1'b0, C_NO_REQ,    1'b0, S_IDLE);
         S_DISP0: w = cw(1'b0, PUT_NONE, 1'b0, 1'b0, 1'b0, 1'b0, C_OPERAND,   1'b0, S_OPND);
         S_DISP1: w = cw(1'b0, PUT_NONE, 1'b0, 1'b0, 1'b0, 1'b0, C_OPEN,      1'b0, S_OPEN);
         S_DISP2: w = cw(1'b0, PUT_NONE, 1'b0, 1'b0, 1'b0, 1'b0, C_CLOSE,     1'b0, S_CLOSE);
         S_OPER:  w = cw(1'b0, PUT_NONE, 1'b0, 1'b0, 1'b0, 1'b0, C_EMPTY,     1'b0, S_PUSH);
         S_OPCMP: w = cw(1'b0, PUT_NONE, 1'b0, 1'b0, 1'b0, 1'b0, C_PREC_POPS, 1'b1, S_PUSH);
         S_OPPOP: w = cw(1'b0, PUT_TOP,  1'b1, 1'b0, 1'b0, 1'b0, C_ALWAYS,    1'b0, S_OPER);
         S_PUSH:  w = cw(1'b0, PUT_NONE, 1'b0, 1'b1, 1'b0, 1'b0, C_ALWAYS,    1'b0, S_LAST);
         S_OPND:  w = cw(1'b0, PUT_CHAR, 1'b0, 1'b0, 1'b0, 1'b0, C_ALWAYS,    1'b0, S_LAST);
         S_OPEN:  w = cw(1'b0, PUT_NONE, 1'b0, 1'b1, 1'b0, 1'b0, C_ALWAYS,    1'b0, S_LAST);
         S_CLOSE: w = cw(1'b0, PUT_NONE, 1'b0, 1'b0, 1'b0, 1'b0, C_EMPTY,     1'b0, S_UNM);
         S_CLTOP: w = cw(1'b0, PUT_NONE, 1'b0, 1'b0, 1'b0, 1'b0, C_TOP_OPEN,  1'b0, S_DROP);
         S_CLPOP: w = cw(1'b0, PUT_TOP,  1'b1, 1'b0, 1'b0, 1'b0, C_ALWAYS,    1'b0, S_CLOSE);
         S_UNM:   w = cw(1'b0, PUT_NONE, 1'b0, 1'b0, 1'b1, 1'b0, C_ALWAYS,    1'b0, S_LAST);
         S_DROP:  w = cw(1'b0, PUT_NONE, 1'b1, 1'b0, 1'b0, 1'b0, C_NEVER,     1'b0, S_IDLE);
         S_LAST:  w = cw(1'b0, PUT_NONE, 1'b0, 1'b0, 1'b0, 1'b0, C_LAST,      1'b1, S_FIN);
         S_FLUSH: w = cw(1'b0, PUT_NONE, 1'b0, 1'b0, 1'b0, 1'b0, C_EMPTY,     1'b0, S_FIN);
         S_FLPOP: w = cw(1'b0, PUT_TOP,  1'b1, 1'b0, 1'b0, 1'b0, C_ALWAYS,    1'b0, S_FLUSH);
         S_FIN:   w = cw(1'b0, PUT_NONE, 1'b0, 1'b0, 1'b0, 1'b1, C_ALWAYS,    1'b0, S_IDLE);
         default: w = cw(1'b0, PUT_NONE, 1'b0, 1'b0, 1'b0, 1'b0, C_ALWAYS,    1'b0, S_IDLE);
      endcase
      return w;
   endfunction

endpackage

FILE: rtl/infix_to_postfix_converter.sv
// Shunting-yard infix to postfix converter: one ASCII character per input
// transfer, with req_in_last marking the end of the expression. Operands are
// emitted at once, operators wait on a 16-entry stack, and the last character
// flushes the stack; the final result of an expression carries rsp_end_mark,
// and an expression that yields nothing still gives one empty end-marked
// result. rsp_status reports the first unmatched ')' or stack overflow of the
// expression on every result that follows it. A small microprogram steps
// through each character, and the block takes no new character until it
// has finished the last one; a step that has a result to pass on holds
// while the result register is stalled.
module infix_to_postfix_converter
   import i2p_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_char,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_has_char,
   output logic       rsp_end_mark,
   output logic [1:0] rsp_status
);

   ctl_word_type ctl;
   dp_flags_type flags;

   // Microprogram sequencer.
   i2p_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctl   (ctl)
   );

   // Stack, error tracking and result registers.
   i2p_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .flags        (flags),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_char  (req_in_char),
      .req_in_last  (req_in_last),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_char (rsp_out_char),
      .rsp_has_char (rsp_has_char),
      .rsp_end_mark (rsp_end_mark),
      .rsp_status   (rsp_status)
   );

endmodule

FILE: rtl/i2p_ram.sv
module i2p_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single write port, registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/i2p_sequencer.sv
module i2p_sequencer
   import i2p_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  dp_flags_type flags,
   output ctl_word_type ctl
);

   logic [UPC_W-1:0] upc_ff;
   logic [UPC_W-1:0] upc_in;
   logic             cond_val;

   // Fetch the control word of the current step.
   assign ctl = microcode(upc_ff);

   // Evaluate the branch condition named by the control word.
   always_comb begin
      case (ctl.cond)
         C_NEVER:     cond_val = 1'b0;
         C_ALWAYS:    cond_val = 1'b1;
         C_NO_REQ:    cond_val = flags.no_req;
         C_OPERAND:   cond_val = flags.operand;
         C_OPEN:      cond_val = flags.open;
         C_CLOSE:     cond_val = flags.close;
         C_EMPTY:     cond_val = flags.empty;
         C_TOP_OPEN:  cond_val = flags.top_open;
         C_PREC_POPS: cond_val = flags.prec_pops;
         C_LAST:      cond_val = flags.last;
         default:     cond_val = 1'b0;
      endcase
   end

   // Hold while the result register is blocked, else branch or step on.
   always_comb begin
      if (flags.hold) begin
         upc_in = upc_ff;
      end else if (cond_val ^ ctl.inv) begin
         upc_in = ctl.target;
      end else begin
         upc_in = upc_ff + UPC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= S_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

FILE: rtl/i2p_datapath.sv
module i2p_datapath
   import i2p_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  ctl_word_type ctl,
   output dp_flags_type flags,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [7:0]   req_in_char,
   input  logic         req_in_last,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [7:0]   rsp_out_char,
   output logic         rsp_has_char,
   output logic         rsp_end_mark,
   output logic [1:0]   rsp_status
);

   logic [7:0]       char_ff;
   logic             last_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [1:0]       err_ff;
   logic [1:0]       err_in;

   logic             pend_valid_ff;
   logic [7:0]       pend_char_ff;
   logic [1:0]       pend_status_ff;

   logic             out_valid_ff;
   logic [7:0]       out_char_ff;
   logic             out_has_ff;
   logic             out_end_ff;
   logic [1:0]       out_status_ff;

   logic [7:0]       top;
   logic             full;
   logic             out_free;
   logic             need_out;
   logic             go;
   logic             do_put;
   logic             do_push;
   logic             load_out;
   logic [7:0]       put_char;

   // Stack of pending operators; the read port tracks the top, but a freshly pushed entry is not yet seen there.
   i2p_ram #(
      .WIDTH (8),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (do_push),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (char_ff),
      .rd_addr (IDX_W'(count_in - CNT_W'(1))),
      .rd_data (top)
   );

   assign full     = (count_ff == CNT_W'(STACK_DEPTH));
   assign out_free = !out_valid_ff || !rsp_stall;

   // A step that hands something to the result register waits until it is free.
   assign need_out = ((ctl.put != PUT_NONE) && pend_valid_ff) ||
                     (ctl.fin && (pend_valid_ff || last_ff));
   assign go       = !(need_out && !out_free);
   assign do_put   = go && (ctl.put != PUT_NONE);
   assign do_push  = go && ctl.push && !full;
   assign put_char = (ctl.put == PUT_TOP) ? top : char_ff;
   assign load_out = go && need_out;

   // Flags for the sequencer's branches.
   always_comb begin
      flags.no_req    = !req_valid;
      flags.operand   = is_operand(char_ff);
      flags.open      = (char_ff == CH_LPAREN);
      flags.close     = (char_ff == CH_RPAREN);
      flags.empty     = (count_ff == '0);
      flags.top_open  = (top == CH_LPAREN);
      flags.prec_pops = (prec_of(char_ff) <= prec_of(top));
      flags.last      = last_ff;
      flags.hold      = !go;
   end

   assign req_stall = !ctl.take;

   // Latch the character on an input transfer.
   always_ff @(posedge clock) begin
      if (ctl.take && req_valid) begin
         char_ff <= req_in_char;
         last_ff <= req_in_last;
      end
   end

   // Stack depth and sticky error code.
   always_comb begin
      count_in = count_ff;
      err_in   = err_ff;
      if (go && ctl.pop) begin
         count_in = count_ff - CNT_W'(1);
      end
      if (go && ctl.push) begin
         if (full) begin
            if (err_ff == ST_OK) begin
               err_in = ST_OVERFLOW;
            end
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end
      if (go && ctl.flag_close && (err_ff == ST_OK)) begin
         err_in = ST_UNMATCHED;
      end
      if (go && ctl.fin && last_ff) begin
         count_in = '0;
         err_in   = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         err_ff   <= ST_OK;
      end else begin
         count_ff <= count_in;
         err_ff   <= err_in;
      end
   end

   // One result is held back so the final one can carry the end mark.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (do_put) begin
         pend_valid_ff <= 1'b1;
      end else if (go && ctl.fin) begin
         pend_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (do_put) begin
         pend_char_ff   <= put_char;
         pend_status_ff <= err_ff;
      end
   end

   // Result register toward the consumer.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (load_out) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         if (pend_valid_ff) begin
            out_char_ff   <= pend_char_ff;
            out_has_ff    <= 1'b1;
            out_end_ff    <= ctl.fin && last_ff;
            out_status_ff <= pend_status_ff;
         end else begin
            out_char_ff   <= CH_NONE;
            out_has_ff    <= 1'b0;
            out_end_ff    <= 1'b1;
            out_status_ff <= err_ff;
         end
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_char = out_char_ff;
   assign rsp_has_char = out_has_ff;
   assign rsp_end_mark = out_end_ff;
   assign rsp_status   = out_status_ff;

endmodule

FILE: verif/infix_to_postfix_converter_tb.sv
`timescale 1ns / 1ps

module infix_to_postfix_converter_tb;
   import i2p_pkg::*;

   localparam int RANDOM_CHARS   = 108;
   localparam int CALM_AFTER     = 85;
   localparam int LONG_HOLD      = 80;
   localparam int DRAIN_CYCLES   = 200;
   localparam int WATCHDOG_LIMIT = 2000;

   // One postfix result as seen on the output channel.
   typedef struct packed {
      logic [7:0] ch;
      logic       has_char;
      logic       end_mark;
      logic [1:0] status;
   } postfix_out_type;

   // Shadow operator stack: predicts the postfix stream and checks it in order.
   class postfix_tracker;
      logic [7:0]      op_stack [STACK_DEPTH];
      int              depth = 0;
      logic [1:0]      sticky_status = ST_OK;
      postfix_out_type pending_out [$];
      int              mismatches = 0;
      int              expressions = 0;
      int              chars = 0;
      int              results = 0;
      int              unmatched_exprs = 0;
      int              overflow_exprs = 0;

      function int rank(logic [7:0] c);
         case (c)
            CH_PLUS, CH_MINUS: return 1;
            CH_STAR, CH_SLASH: return 2;
            CH_CARET:          return 3;
            CH_LPAREN:         return 0;
            default:           return -1;
         endcase
      endfunction

      function bit is_operand(logic [7:0] c);
         return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9");
      endfunction

      function void emit(logic [7:0] c, logic has);
         postfix_out_type r;
         r.ch       = c;
         r.has_char = has;
         r.end_mark = 1'b0;
         r.status   = sticky_status;
         pending_out.push_back(r);
      endfunction

      // Only the first error of an expression is kept.
      function void raise(logic [1:0] code);
         if (sticky_status == ST_OK) sticky_status = code;
      endfunction

      function void push_op(logic [7:0] c);
         if (depth >= STACK_DEPTH) begin
            raise(ST_OVERFLOW);
         end else begin
            op_stack[depth] = c;
            depth++;
         end
      endfunction

      // Work out the results caused by one accepted character.
      function void accept_char(logic [7:0] c, logic last);
         int         queued_at_start;
         bit         found;
         logic [7:0] top;
         queued_at_start = pending_out.size();
         found = 1'b0;
         chars++;
         if (is_operand(c)) begin
            emit(c, 1'b1);
         end else if (c == CH_LPAREN) begin
            push_op(c);
         end else if (c == CH_RPAREN) begin
            while (depth > 0) begin
               top = op_stack[depth - 1];
               depth--;
               if (top == CH_LPAREN) begin
                  found = 1'b1;
                  break;
               end
               emit(top, 1'b1);
            end
            if (!found) raise(ST_UNMATCHED);
         end else begin
            while (depth > 0 && rank(c) <= rank(op_stack[depth - 1])) begin
               emit(op_stack[depth - 1], 1'b1);
               depth--;
            end
            push_op(c);
         end
         // The final character flushes the stack and marks the last result.
         if (last) begin
            while (depth > 0) begin
               emit(op_stack[depth - 1], 1'b1);
               depth--;
            end
            if (pending_out.size() == queued_at_start) emit(CH_NONE, 1'b0);
            pending_out[pending_out.size() - 1].end_mark = 1'b1;
            expressions++;
            if (sticky_status == ST_UNMATCHED) unmatched_exprs++;
            if (sticky_status == ST_OVERFLOW) overflow_exprs++;
            depth = 0;
            sticky_status = ST_OK;
         end
      endfunction

      function void check_emitted(postfix_out_type got);
         postfix_out_type want;
         results++;
         if (pending_out.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result: char %h has %b end %b status %0d",
                     $time, got.ch, got.has_char, got.end_mark, got.status);
            return;
         end
         want = pending_out.pop_front();
         if (got.ch !== want.ch || got.has_char !== want.has_char ||
             got.end_mark !== want.end_mark || got.status !== want.status) begin
            mismatches++;
            $display("%0t: mismatch: expected char %h has %b end %b status %0d,",
                     $time, want.ch, want.has_char, want.end_mark, want.status,
                     " got char %h has %b end %b status %0d",
                     got.ch, got.has_char, got.end_mark, got.status);
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_char = 8'h00;
   logic       req_in_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_char;
   logic       rsp_has_char;
   logic       rsp_end_mark;
   logic [1:0] rsp_status;

   postfix_tracker tracker = new;
   logic [7:0]     expr_q [$];
   bit             bursts_on = 1'b1;
   bit             hold_pending = 1'b0;
   int             random_sent = 0;

   infix_to_postfix_converter i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_char  (req_in_char),
      .req_in_last  (req_in_last),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_char (rsp_out_char),
      .rsp_has_char (rsp_has_char),
      .rsp_end_mark (rsp_end_mark),
      .rsp_status   (rsp_status)
   );

   always #1 clock = ~clock;

   function automatic logic [7:0] pick_operand();
      int         k;
      logic [7:0] c;
      k = $urandom_range(0, 61);
      if (k < 26) begin
         c = "a";
         c = c + 8'(k);
      end else if (k < 52) begin
         c = "A";
         c = c + 8'(k - 26);
      end else begin
         c = "0";
         c = c + 8'(k - 52);
      end
      return c;
   endfunction

   function automatic logic [7:0] pick_operator();
      case ($urandom_range(0, 4))
         0:       return CH_PLUS;
         1:       return CH_MINUS;
         2:       return CH_STAR;
         3:       return CH_SLASH;
         default: return CH_CARET;
      endcase
   endfunction

   // Offer one character, with an optional idle gap first, and wait for its transfer.
   task automatic send_char(input logic [7:0] c, input logic last);
      int gap;
      if (bursts_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_char <= c;
      req_in_last <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.accept_char(c, last);
   endtask

   // Send the queued expression, with the last flag on its final character.
   task automatic send_expression();
      for (int i = 0; i < expr_q.size(); i++) send_char(expr_q[i], i == expr_q.size() - 1);
      expr_q.delete();
   endtask

   task automatic queue_text(input string s);
      for (int i = 0; i < s.len(); i++) expr_q.push_back(s[i]);
   endtask

   // Balanced expression with random operands, operators and groups.
   task automatic build_wellformed(input int max_depth, input int open_pct);
      int ops_left;
      int level;
      ops_left = $urandom_range(0, 5);
      level = 0;
      while (1) begin
         while (level < max_depth && $urandom_range(0, 99) < open_pct) begin
            expr_q.push_back(CH_LPAREN);
            level++;
         end
         expr_q.push_back(pick_operand());
         while (level > 0 && $urandom_range(0, 1) == 1) begin
            expr_q.push_back(CH_RPAREN);
            level--;
         end
         if (ops_left == 0) break;
         ops_left--;
         expr_q.push_back(pick_operator());
      end
      repeat (level) expr_q.push_back(CH_RPAREN);
   endtask

   // Deep nesting that can drive the operator stack to or past its capacity.
   task automatic build_nested(input int opens);
      repeat (opens) begin
         if ($urandom_range(0, 1) == 1) begin
            expr_q.push_back(pick_operand());
            expr_q.push_back(pick_operator());
         end
         expr_q.push_back(CH_LPAREN);
      end
      expr_q.push_back(pick_operand());
      repeat ($urandom_range(0, opens)) expr_q.push_back(CH_RPAREN);
   endtask

   // Short runs of arbitrary bytes, stray parentheses and operators.
   task automatic build_noise();
      repeat ($urandom_range(1, 6)) begin
         case ($urandom_range(0, 3))
            0, 1:    expr_q.push_back(8'($urandom_range(0, 255)));
            2:       expr_q.push_back($urandom_range(0, 1) ? CH_LPAREN : CH_RPAREN);
            default: expr_q.push_back(pick_operator());
         endcase
      end
   endtask

   // Receiver: random stall bursts, plus one long hold-off on request.
   initial begin : receiver
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (hold_pending) begin
            hold_pending = 1'b0;
            stall_left = LONG_HOLD - 1;
            rsp_stall <= 1'b1;
         end else if (bursts_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 4);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Check every result transfer against the oldest prediction.
   always @(posedge clock) begin : result_monitor
      postfix_out_type seen;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.ch       = rsp_out_char;
         seen.has_char = rsp_has_char;
         seen.end_mark = rsp_end_mark;
         seen.status   = rsp_status;
         tracker.check_emitted(seen);
      end
   end

   // End the run if neither channel makes a transfer for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      @(negedge reset);
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   initial begin : stimulus
      int mode;
      int pos;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed expressions: all operators, grouping, left-associative power.
      queue_text("(a+B)*9");
      send_expression();
      queue_text("z-0/Z^a^b");
      send_expression();
      // A lone closing parenthesis gives only an empty end marker with an error.
      queue_text(")");
      send_expression();
      // Characters without precedence, including both byte extremes.
      expr_q.push_back(CH_NONE);
      queue_text("x ");
      expr_q.push_back(8'hFF);
      send_expression();
      // An open parenthesis left on the stack is flushed as a character.
      queue_text("(");
      send_expression();

      // Stall the output for a long stretch while a stack overflow is fed in.
      hold_pending = 1'b1;
      build_nested(17);
      random_sent += expr_q.size();
      send_expression();

      // Mostly well-formed expressions, some broken, some deep, some noise.
      while (random_sent < RANDOM_CHARS) begin
         if (random_sent >= CALM_AFTER) bursts_on = 1'b0;
         mode = $urandom_range(0, 99);
         if (mode < 8) begin
            build_nested($urandom_range(12, 18));
         end else if (mode < 25) begin
            build_noise();
         end else begin
            build_wellformed(4, 25);
            if ($urandom_range(0, 4) == 0 && expr_q.size() > 1) begin
               pos = $urandom_range(0, expr_q.size() - 1);
               if ($urandom_range(0, 1) == 1) expr_q.delete(pos);
               else expr_q.insert(pos, pick_operator());
            end
         end
         random_sent += expr_q.size();
         send_expression();
      end
      req_valid <= 1'b0;

      // Drain the remaining results, then allow time for anything extra.
      while (tracker.pending_out.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Converted %0d expressions (%0d characters) into %0d postfix results,",
               tracker.expressions, tracker.chars, tracker.results);
      $display("with %0d unmatched-parenthesis and %0d stack-overflow expressions.",
               tracker.unmatched_exprs, tracker.overflow_exprs);
      if (tracker.mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
